// ----- rtl/bgi_pkg.sv -----
// shared types and constants for the bilinear grid interpolator
// no dependencies; imported by every module of the block except bgi_ram
package bgi_pkg;

	localparam int DATA_W       = 32;
	localparam int CNT_W        = 7;
	localparam int WGT_W        = 17;
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;

	typedef enum logic [1:0] {
		OP_WR_ROW  = 2'd0,
		OP_WR_COL  = 2'd1,
		OP_WR_GRID = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

	typedef enum logic {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_FIRST,
		S_RD_LAST,
		S_RANGE,
		S_BS_RD,
		S_BS_EV,
		S_DEGEN,
		S_DIV,
		S_GRD,
		S_BLST,
		S_BLEND,
		S_DONE
	} state_t;

endpackage

// ----- rtl/bgi_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on nothing
module bgi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/bgi_div.sv -----
// restoring divider for one cell weight, one quotient bit per cycle
// depends on bgi_pkg
module bgi_div
	import bgi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  logic signed [32:0] den,
	output logic               done,
	output logic [WGT_W-1:0]   quo
);

	logic [32:0]      nm, dm, dm_q;
	logic [33:0]      rem_q, rem_sh;
	logic [WGT_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             busy_q, done_q, qbit;

	assign nm     = num[32] ? 33'(-num) : 33'(num);
	assign dm     = den[32] ? 33'(-den) : 33'(den);
	assign rem_sh = {rem_q[32:0], 1'b0};
	assign qbit   = rem_sh >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			cnt_q <= '0;
			// opposite signs or a zero numerator give zero, a ratio of one or more clamps to one
			if (num[32] != den[32] || num == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (nm >= dm) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dm_q  <= dm;
			rem_q <= {1'b0, nm};
			if (num[32] != den[32] || num == '0) begin
				quo_q <= '0;
			end else if (nm >= dm) begin
				quo_q <= WGT_ONE;
			end else begin
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_sh - {1'b0, dm_q}) : rem_sh;
			quo_q <= {quo_q[WGT_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/bgi_blend.sv -----
// four-corner bilinear blend, one weight product and two partial products per corner
// depends on bgi_pkg
module bgi_blend
	import bgi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [WGT_W-1:0]       wu,
	input  logic [WGT_W-1:0]       wt,
	input  logic [3:0][DATA_W-1:0] corner,
	output logic                   done,
	output logic [DATA_W-1:0]      value
);

	logic [1:0]               k_q, ph_q;
	logic                     busy_q, done_q;
	logic [WGT_W-1:0]         wa, wb;
	logic [33:0]              wp_q;
	logic signed [DATA_W-1:0] g_sel;
	logic signed [48:0]       prod_lo;
	logic signed [49:0]       prod_hi;
	logic signed [65:0]       acc_q, acc_rnd;

	// corner order: (lo,lo) (lo,hi) (hi,hi) (hi,lo)
	assign wa      = (k_q == 2'd0 || k_q == 2'd1) ? (WGT_ONE - wu) : wu;
	assign wb      = (k_q == 2'd1 || k_q == 2'd2) ? wt : (WGT_ONE - wt);
	assign g_sel   = $signed(corner[k_q]);
	assign prod_lo = g_sel * $signed({1'b0, wp_q[15:0]});
	assign prod_hi = g_sel * $signed({1'b0, wp_q[32:16]});
	assign acc_rnd = acc_q + 66'sd2147483648;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			ph_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			k_q    <= '0;
			ph_q   <= '0;
		end else if (busy_q) begin
			if (ph_q == 2'd2) begin
				ph_q <= '0;
				k_q  <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: wp_q <= {17'b0, wa} * {17'b0, wb};
				2'd1: acc_q <= acc_q + 66'(prod_lo);
				2'd2: acc_q <= acc_q + (66'(prod_hi) <<< 16);
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done  = done_q;
	assign value = acc_rnd[63:32];

endmodule

// ----- rtl/bilinear_grid_interpolator.sv -----
// bilinear grid interpolator top level: axis and grid memories, query sequencer, output register
// depends on bgi_pkg, bgi_ram, bgi_div and bgi_blend
//
// Load the two ascending axis tables and the sample grid with write transfers
// (opcodes 0..2), set row_count/col_count on the config port, then send query
// transfers (opcode 3); each query returns exactly one result, writes return none.
// A query walks a sequencer over the three memories: two reads for the axis end
// points, a bisection that reads both axes in parallel with a read state and an
// evaluate state per halving step (at most ceil(log2(count-1)) steps on the longer
// axis) plus a closing read state, a restoring division for both weights in parallel
// (no division steps when both weights clamp without dividing), four grid reads and
// a multiply-accumulate blend. Out-of-range queries go from the range check straight
// to the result. The input stalls while a query is in flight; a finished result sits
// in the output register so the next transfer can be taken while it waits. Status 1
// flags coordinates outside the axis span, status 2 a zero-width cell; the value is
// then zero.
module bilinear_grid_interpolator
	import bgi_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [5:0]        row_index,
	input  logic [5:0]        col_index,
	input  logic [DATA_W-1:0] data_value,
	input  logic [DATA_W-1:0] query_x,
	input  logic [DATA_W-1:0] query_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] interp_value,
	output logic [1:0]        status
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int GD = MAX_ROWS * MAX_COLS;
	localparam int GW = $clog2(GD);

	state_t state_q, state_d;

	// config registers
	logic [CNT_W-1:0] row_count_q, col_count_q;
	logic [RW-1:0]    rlast;
	logic [CW-1:0]    clast;

	// query context
	logic signed [DATA_W-1:0] qx_q, qy_q;
	logic signed [DATA_W-1:0] rfirst_q, cfirst_q;
	logic signed [DATA_W-1:0] rlv_q, rhv_q, clv_q, chv_q;
	logic [RW-1:0]            ra_q, rb_q, rmid;
	logic [CW-1:0]            ca_q, cb_q, cmid;
	logic [RW:0]              rsum;
	logic [CW:0]              csum;
	logic                     r_act, c_act;
	logic                     out_of_range, degen;
	logic [3:0][DATA_W-1:0]   g_q;
	logic [2:0]               gcnt_q;
	logic [GW-1:0]            gaddr_rd;

	// memories
	logic                in_xfer, op_row, op_col, op_grid;
	logic [RW-1:0]       row_raddr;
	logic [CW-1:0]       col_raddr;
	logic [DATA_W-1:0]   row_rdata, col_rdata, grid_rdata;
	logic signed [DATA_W-1:0] row_rs, col_rs;

	// arithmetic units
	logic               div_start, blend_start;
	logic               rdiv_done, cdiv_done, blend_done;
	logic [WGT_W-1:0]   wu, wt;
	logic [DATA_W-1:0]  blend_value;
	logic signed [32:0] rnum, rden, cnum, cden;

	// output register
	logic              out_valid_q, out_load;
	logic [DATA_W-1:0] interp_value_q;
	status_t           status_q, res_status;
	logic [DATA_W-1:0] res_value;

	assign in_xfer = in_valid && !in_stall;
	assign op_row  = in_xfer && opcode == OP_WR_ROW  && int'(row_index) < MAX_ROWS;
	assign op_col  = in_xfer && opcode == OP_WR_COL  && int'(col_index) < MAX_COLS;
	assign op_grid = in_xfer && opcode == OP_WR_GRID && int'(row_index) < MAX_ROWS
		&& int'(col_index) < MAX_COLS;

	// last index in use, count clamped to 2..MAX
	always_comb begin
		if (row_count_q < CNT_W'(2)) begin
			rlast = RW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rlast = RW'(MAX_ROWS - 1);
		end else begin
			rlast = RW'(int'(row_count_q) - 1);
		end
		if (col_count_q < CNT_W'(2)) begin
			clast = CW'(1);
		end else if (int'(col_count_q) > MAX_COLS) begin
			clast = CW'(MAX_COLS - 1);
		end else begin
			clast = CW'(int'(col_count_q) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_W'(2);
			col_count_q <= CNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROWS: row_count_q <= cfg_wdata;
				CFG_COLS: col_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bgi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_row_ram (
		.clk   (clk),
		.we    (op_row),
		.waddr (RW'(row_index)),
		.wdata (data_value),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	bgi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_col_ram (
		.clk   (clk),
		.we    (op_col),
		.waddr (CW'(col_index)),
		.wdata (data_value),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	bgi_ram #(.WIDTH(DATA_W), .DEPTH(GD)) u_grid_ram (
		.clk   (clk),
		.we    (op_grid),
		.waddr (GW'(int'(row_index) * MAX_COLS + int'(col_index))),
		.wdata (data_value),
		.raddr (gaddr_rd),
		.rdata (grid_rdata)
	);

	assign row_rs = $signed(row_rdata);
	assign col_rs = $signed(col_rdata);

	// bisection midpoints, a search is live while its bracket spans more than one cell
	assign rsum  = {1'b0, ra_q} + {1'b0, rb_q};
	assign csum  = {1'b0, ca_q} + {1'b0, cb_q};
	assign rmid  = rsum[RW:1];
	assign cmid  = csum[CW:1];
	assign r_act = ({1'b0, rb_q} - {1'b0, ra_q}) > (RW + 1)'(1);
	assign c_act = ({1'b0, cb_q} - {1'b0, ca_q}) > (CW + 1)'(1);

	// checked in S_RANGE, where the read data holds the last axis points
	assign out_of_range = qx_q > row_rs || qx_q < rfirst_q || qy_q > col_rs || qy_q < cfirst_q;
	assign degen        = rhv_q == rlv_q || chv_q == clv_q;

	// grid corner address for the read issued at gcnt
	always_comb begin
		case (gcnt_q[1:0])
			2'd0: gaddr_rd = GW'(int'(ra_q) * MAX_COLS + int'(ca_q));
			2'd1: gaddr_rd = GW'(int'(ra_q) * MAX_COLS + int'(cb_q));
			2'd2: gaddr_rd = GW'(int'(rb_q) * MAX_COLS + int'(cb_q));
			default: gaddr_rd = GW'(int'(rb_q) * MAX_COLS + int'(ca_q));
		endcase
	end

	assign rnum = $signed({qx_q[DATA_W-1], qx_q}) - $signed({rlv_q[DATA_W-1], rlv_q});
	assign rden = $signed({rhv_q[DATA_W-1], rhv_q}) - $signed({rlv_q[DATA_W-1], rlv_q});
	assign cnum = $signed({qy_q[DATA_W-1], qy_q}) - $signed({clv_q[DATA_W-1], clv_q});
	assign cden = $signed({chv_q[DATA_W-1], chv_q}) - $signed({clv_q[DATA_W-1], clv_q});

	bgi_div u_row_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rnum),
		.den    (rden),
		.done   (rdiv_done),
		.quo    (wu)
	);

	bgi_div u_col_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cnum),
		.den    (cden),
		.done   (cdiv_done),
		.quo    (wt)
	);

	bgi_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.wu     (wu),
		.wt     (wt),
		.corner (g_q),
		.done   (blend_done),
		.value  (blend_value)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_xfer && opcode == OP_QUERY) state_d = S_RD_FIRST;
			S_RD_FIRST: state_d = S_RD_LAST;
			S_RD_LAST:  state_d = S_RANGE;
			S_RANGE:    state_d = out_of_range ? S_DONE : S_BS_RD;
			S_BS_RD:    state_d = (r_act || c_act) ? S_BS_EV : S_DEGEN;
			S_BS_EV:    state_d = S_BS_RD;
			S_DEGEN:    state_d = degen ? S_DONE : S_DIV;
			S_DIV:      if (rdiv_done && cdiv_done) state_d = S_GRD;
			S_GRD:      if (gcnt_q == 3'd4) state_d = S_BLST;
			S_BLST:     state_d = S_BLEND;
			S_BLEND:    if (blend_done) state_d = S_DONE;
			S_DONE:     if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall    = 1'b1;
		row_raddr   = rmid;
		col_raddr   = cmid;
		div_start   = 1'b0;
		blend_start = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_RD_FIRST: begin
				row_raddr = '0;
				col_raddr = '0;
			end
			S_RD_LAST: begin
				row_raddr = rlast;
				col_raddr = clast;
			end
			S_DEGEN: div_start = !degen;
			S_BLST:  blend_start = 1'b1;
			S_DONE:  out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_GRD) begin
				gcnt_q <= gcnt_q + 3'd1;
			end else begin
				gcnt_q <= '0;
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				qx_q <= $signed(query_x);
				qy_q <= $signed(query_y);
			end
			S_RD_LAST: begin
				rfirst_q <= row_rs;
				cfirst_q <= col_rs;
			end
			S_RANGE: begin
				ra_q  <= '0;
				rb_q  <= rlast;
				ca_q  <= '0;
				cb_q  <= clast;
				rlv_q <= rfirst_q;
				clv_q <= cfirst_q;
				rhv_q <= row_rs;
				chv_q <= col_rs;
				res_status <= ST_RANGE;
			end
			S_BS_EV: begin
				if (r_act) begin
					if (row_rs > qx_q) begin
						rb_q  <= rmid;
						rhv_q <= row_rs;
					end else begin
						ra_q  <= rmid;
						rlv_q <= row_rs;
					end
				end
				if (c_act) begin
					if (col_rs > qy_q) begin
						cb_q  <= cmid;
						chv_q <= col_rs;
					end else begin
						ca_q  <= cmid;
						clv_q <= col_rs;
					end
				end
			end
			S_DEGEN: res_status <= degen ? ST_DEGEN : ST_OK;
			S_GRD: if (gcnt_q != 3'd0) g_q[gcnt_q[1:0] - 2'd1] <= grid_rdata;
			default: ;
		endcase
	end

	assign res_value = (res_status == ST_OK) ? blend_value : '0;

	// output register, holds a finished result while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			interp_value_q <= res_value;
			status_q       <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign interp_value = interp_value_q;
	assign status       = status_q;

	// a non-ok result never carries a value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> interp_value_q == '0)
		else $error("non-ok result with nonzero value");

	// bisection brackets stay ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BS_RD |-> ra_q < rb_q && ca_q < cb_q)
		else $error("bisection bracket collapsed");

	// weights are clamped to one
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BLEND |-> wu <= WGT_ONE && wt <= WGT_ONE)
		else $error("weight above one");

	// a load transfer never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && opcode != OP_QUERY && !out_valid_q |=> !out_valid_q)
		else $error("result after a write transfer");

endmodule
